FILE: hdl/segcom_pkg.sv
// Shared widths, register indexes and types for the segment center-of-mass unit.
`timescale 1ns / 1ps

package segcom_pkg;

    localparam int COORD_W    = 32;
    localparam int BOX_W      = 31;
    localparam int SPC_W      = 11;
    localparam int CPF_W      = 16;
    localparam int SEG_W      = 10;
    localparam int CHN_W      = 16;
    localparam int CNT_W      = 11;
    localparam int SUM_W      = 44;
    localparam int FOLD_W     = 33;
    localparam int UNW_W      = 34;
    localparam int DIV_W      = 32;
    localparam int QUO_W      = 44;
    localparam int STEP_W     = 6;
    localparam int FOLD_STEPS = 33;
    localparam int MEAN_STEPS = 44;
    localparam int MAX_BEADS  = 1024;
    localparam int MAX_SEGS   = 1024;
    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 31;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGS_CHAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAINS_FRM = 2'd2;

    localparam logic [BOX_W-1:0] BOX_RESET = 31'd2097152;
    localparam logic [SPC_W-1:0] SPC_RESET = 11'd1;
    localparam logic [CPF_W-1:0] CPF_RESET = 16'd1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]   t_sum;

endpackage

FILE: hdl/segment_center_of_mass_periodic_unit.sv
// Segment center of mass with periodic minimum-image unwrapping, one shared serial divider.
`timescale 1ns / 1ps
// A bead keeps the unit busy after its accept with a 33-step fold divide per axis plus
// load, fold and accumulate; with box_length zero the divide is skipped, and a bead that
// overflows the count is not accumulated. A new bead is taken only once the unit is idle.
// A last bead then runs the mean divides (44 steps each) plus any wait for the output
// register to drain before its result shows.
// Reset (synchronous, active low) clears sums, counts, indexes, references and output valid, and loads config resets.

module segment_center_of_mass_periodic_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [segcom_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [segcom_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [segcom_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [segcom_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [segcom_pkg::COORD_W-1:0] i_coord_z,
    input  logic                               i_last_bead,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [segcom_pkg::CHN_W-1:0]       o_chain_number,
    output logic [segcom_pkg::SPC_W-1:0]       o_segment_number,
    output logic signed [segcom_pkg::COORD_W-1:0] o_center_x,
    output logic signed [segcom_pkg::COORD_W-1:0] o_center_y,
    output logic signed [segcom_pkg::COORD_W-1:0] o_center_z,
    output logic                               o_count_overflow
);
    import segcom_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_AXIS  = 3'd1;
    localparam logic [2:0] S_FDIV  = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_MWAIT = 3'd5;
    localparam logic [2:0] S_MLOAD = 3'd6;
    localparam logic [2:0] S_MDIV  = 3'd7;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);
    localparam logic [QUO_W-1:0]  POS_LIMIT = QUO_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0]  NEG_LIMIT = QUO_W'(64'd1 << (COORD_W - 1));
    localparam logic [COORD_W-1:0] SAT_HI   = COORD_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic [COORD_W-1:0] SAT_LO   = COORD_W'(64'd1 << (COORD_W - 1));

    logic [2:0]             r_state;
    logic [AXIS_W-1:0]      r_ax;
    logic [STEP_W-1:0]      r_cnt;
    logic                   r_mout;

    logic [BOX_W-1:0]       r_box;
    logic [SPC_W-1:0]       r_spc;
    logic [CPF_W-1:0]       r_cpf;

    t_coord                 r_coord [AXES];
    t_coord                 r_ref   [AXES];
    t_sum                   r_sum   [AXES];
    logic                   r_last;
    logic [CNT_W-1:0]       r_count;
    logic                   r_ovf;
    logic [SEG_W-1:0]       r_seg;
    logic [CHN_W-1:0]       r_chn;

    // shared restoring divider
    logic [DIV_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_q;
    logic [DIV_W-1:0]       r_div;
    logic                   r_neg;
    logic signed [FOLD_W-1:0] r_fold;

    logic [DIV_W:0]         n_rem_sh;
    logic [DIV_W:0]         n_rem_diff;
    logic                   n_ge;
    logic [DIV_W-1:0]       n_rem;
    logic [QUO_W-1:0]       n_q;

    t_coord                 n_xa;
    logic [COORD_W-1:0]     n_xmag;
    logic [FOLD_W-1:0]      n_num;

    logic signed [FOLD_W-1:0] n_t;
    logic signed [FOLD_W-1:0] n_half;
    logic signed [FOLD_W-1:0] n_fold;

    logic signed [UNW_W-1:0]  n_fold_x;
    logic signed [UNW_W-1:0]  n_box_x;
    logic signed [UNW_W-1:0]  n_diff;
    logic signed [UNW_W:0]    n_diff2;
    logic signed [UNW_W:0]    n_box2;
    logic signed [UNW_W-1:0]  n_unwrap;

    t_sum                   n_sum_cur;
    logic [QUO_W-1:0]       n_sum_mag;
    logic [QUO_W-1:0]       n_qneg;
    logic [COORD_W-1:0]     n_mean;

    logic [SPC_W-1:0]       n_segs;
    logic [CPF_W-1:0]       n_chains;
    logic [SPC_W-1:0]       n_seg_inc;
    logic [CHN_W:0]         n_chn_inc;

    logic                   n_accept;
    logic                   n_box_zero;

    assign o_stall    = (r_state != S_IDLE);
    assign n_accept   = i_valid && !o_stall;
    assign n_box_zero = (r_box == '0);

    // one divider step per cycle
    always_comb begin
        n_rem_sh   = {r_rem, r_q[QUO_W-1]};
        n_rem_diff = n_rem_sh - {1'b0, r_div};
        n_ge       = (n_rem_sh >= {1'b0, r_div});
        n_rem      = n_ge ? n_rem_diff[DIV_W-1:0] : n_rem_sh[DIV_W-1:0];
        n_q        = {r_q[QUO_W-2:0], n_ge};
    end

    // fold numerator 2|x| + box, divided by 2 box
    always_comb begin
        n_xa   = r_coord[r_ax];
        n_xmag = n_xa[COORD_W-1] ? COORD_W'(-n_xa) : COORD_W'(n_xa);
        n_num  = {n_xmag, 1'b0} + FOLD_W'(r_box);
    end

    // |x| - box*q = (rem - box) / 2, exact since rem and box share parity
    always_comb begin
        n_t    = $signed({1'b0, r_rem}) - $signed(FOLD_W'(r_box));
        n_half = n_t >>> 1;
        n_fold = r_neg ? -n_half : n_half;
    end

    // minimum-image shift against the reference
    always_comb begin
        n_fold_x = UNW_W'(r_fold);
        n_box_x  = $signed(UNW_W'(r_box));
        n_diff   = n_fold_x - UNW_W'(r_ref[r_ax]);
        n_diff2  = {n_diff, 1'b0};
        n_box2   = $signed((UNW_W + 1)'(r_box));
        if (n_box_zero) begin
            n_unwrap = n_fold_x;
        end else if (n_diff2 > n_box2) begin
            n_unwrap = n_fold_x - n_box_x;
        end else if (n_diff2 < -n_box2) begin
            n_unwrap = n_fold_x + n_box_x;
        end else begin
            n_unwrap = n_fold_x;
        end
    end

    // mean magnitude in, signed saturated mean out
    always_comb begin
        n_sum_cur = r_sum[r_ax];
        n_sum_mag = n_sum_cur[SUM_W-1] ? QUO_W'(-n_sum_cur) : QUO_W'(n_sum_cur);
        n_qneg    = -r_q;
        if (!r_neg) begin
            n_mean = (r_q > POS_LIMIT) ? SAT_HI : r_q[COORD_W-1:0];
        end else begin
            n_mean = (r_q > NEG_LIMIT) ? SAT_LO : n_qneg[COORD_W-1:0];
        end
    end

    // segment and chain numbering
    always_comb begin
        if (r_spc == '0) begin
            n_segs = SPC_W'(1);
        end else if (r_spc > SPC_W'(MAX_SEGS)) begin
            n_segs = SPC_W'(MAX_SEGS);
        end else begin
            n_segs = r_spc;
        end
        n_chains  = (r_cpf == '0) ? CPF_W'(1) : r_cpf;
        n_seg_inc = SPC_W'(r_seg) + SPC_W'(1);
        n_chn_inc = (CHN_W + 1)'(r_chn) + (CHN_W + 1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= '0;
            r_cnt   <= '0;
            r_mout  <= 1'b0;
            r_box   <= BOX_RESET;
            r_spc   <= SPC_RESET;
            r_cpf   <= CPF_RESET;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_seg   <= '0;
            r_chn   <= '0;
            o_valid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
                r_ref[a] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BOX_LENGTH: r_box <= i_cfg_data[BOX_W-1:0];
                    REG_SEGS_CHAIN: r_spc <= i_cfg_data[SPC_W-1:0];
                    REG_CHAINS_FRM: r_cpf <= i_cfg_data[CPF_W-1:0];
                    default: ;
                endcase
            end

            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_coord[0] <= i_coord_x;
                        r_coord[1] <= i_coord_y;
                        r_coord[2] <= i_coord_z;
                        r_last     <= i_last_bead;
                        r_ax       <= '0;
                        if (r_count == '0) begin
                            r_ref[0] <= i_coord_x;
                            r_ref[1] <= i_coord_y;
                            r_ref[2] <= i_coord_z;
                        end
                        if (r_count < CNT_W'(MAX_BEADS)) begin
                            r_count <= r_count + CNT_W'(1);
                            r_state <= S_AXIS;
                        end else begin
                            r_ovf   <= 1'b1;
                            r_state <= i_last_bead ? S_MWAIT : S_IDLE;
                        end
                    end
                end
                S_AXIS: begin
                    r_neg <= n_xa[COORD_W-1];
                    if (n_box_zero) begin
                        r_fold  <= FOLD_W'(n_xa);
                        r_state <= S_ACC;
                    end else begin
                        r_rem   <= '0;
                        r_q     <= {n_num, (QUO_W - FOLD_W)'(0)};
                        r_div   <= {r_box, 1'b0};
                        r_cnt   <= STEP_W'(FOLD_STEPS);
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_cnt <= r_cnt - STEP_W'(1);
                    if (r_cnt == STEP_W'(1)) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_fold  <= n_fold;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum[r_ax] <= r_sum[r_ax] + SUM_W'(n_unwrap);
                    if (r_ax == LAST_AXIS) begin
                        r_ax    <= '0;
                        r_state <= r_last ? S_MWAIT : S_IDLE;
                    end else begin
                        r_ax    <= r_ax + AXIS_W'(1);
                        r_state <= S_AXIS;
                    end
                end
                S_MWAIT: begin
                    // results go straight into the output register once it drains
                    if (!o_valid) begin
                        r_ax    <= '0;
                        r_state <= S_MLOAD;
                    end
                end
                S_MLOAD: begin
                    r_neg   <= n_sum_cur[SUM_W-1];
                    r_rem   <= '0;
                    r_q     <= n_sum_mag;
                    r_div   <= DIV_W'(r_count);
                    r_cnt   <= STEP_W'(MEAN_STEPS);
                    r_mout  <= 1'b0;
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    if (!r_mout) begin
                        r_rem <= n_rem;
                        r_q   <= n_q;
                        r_cnt <= r_cnt - STEP_W'(1);
                        if (r_cnt == STEP_W'(1)) begin
                            r_mout <= 1'b1;
                        end
                    end else begin
                        r_mout <= 1'b0;
                        case (r_ax)
                            2'd0:    o_center_x <= n_mean;
                            2'd1:    o_center_y <= n_mean;
                            default: o_center_z <= n_mean;
                        endcase
                        if (r_ax == LAST_AXIS) begin
                            o_valid          <= 1'b1;
                            o_chain_number   <= n_chn_inc[CHN_W-1:0];
                            o_segment_number <= n_seg_inc;
                            o_count_overflow <= r_ovf;
                            for (int a = 0; a < AXES; a++) begin
                                r_sum[a] <= '0;
                            end
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            if (n_seg_inc >= n_segs) begin
                                r_seg <= '0;
                                if (n_chn_inc >= (CHN_W + 1)'(n_chains)) begin
                                    r_chn <= '0;
                                end else begin
                                    r_chn <= n_chn_inc[CHN_W-1:0];
                                end
                            end else begin
                                r_seg <= n_seg_inc[SEG_W-1:0];
                            end
                            r_ax    <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_ax    <= r_ax + AXIS_W'(1);
                            r_state <= S_MLOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
